@@ src/fpa_pkg.sv @@
// Shared types and command codes for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_SUB    = 3'd1,
      CMD_MUL    = 3'd2,
      CMD_DIV    = 3'd3,
      CMD_INC    = 3'd4,
      CMD_DEC    = 3'd5,
      CMD_TO_INT = 3'd6,
      CMD_TO_FIX = 3'd7
   } cmd_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
      logic               divide_by_zero;
   } rsp_type;

   // What travels from one divider cell to the next besides the dividend bits.
   typedef struct packed {
      logic        valid;
      logic        is_div;
      logic        negate;
      logic        div_zero;
      logic        greater;
      logic        less;
      logic        equal;
      logic [31:0] result;
      logic [31:0] rem;
      logic [31:0] divisor;
   } cell_type;

endpackage
`default_nettype wire

@@ src/fpa_front.sv @@
// Operand register, multiplier and per-command result selection ahead of the cell chain.
`default_nettype none
module fpa_front #(
   parameter int FRAC_BITS = 8,
   localparam int DVD_W = 32 + FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire fpa_pkg::req_type req_item,
   output fpa_pkg::cell_type     cell_out,
   output logic [DVD_W-1:0]      dvd_out
);

   logic                valid_ff;
   fpa_pkg::cmd_type    cmd_ff;
   logic signed [31:0]  a_ff;
   logic signed [31:0]  b_ff;
   logic signed [63:0]  prod_ff;
   logic signed [63:0]  prod_in;

   assign prod_in = req_item.operand_a * req_item.operand_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_valid;
      end
      cmd_ff  <= fpa_pkg::cmd_type'(req_item.command);
      a_ff    <= req_item.operand_a;
      b_ff    <= req_item.operand_b;
      prod_ff <= prod_in;
   end

   logic signed [63:0] prod_shift;
   logic signed [31:0] a_shift;
   logic [31:0]        a_mag;
   logic [31:0]        b_mag;
   logic [31:0]        result;

   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign a_shift    = a_ff >>> FRAC_BITS;
   assign a_mag      = a_ff[31] ? (~a_ff + 32'd1) : a_ff;
   assign b_mag      = b_ff[31] ? (~b_ff + 32'd1) : b_ff;

   always_comb begin
      unique case (cmd_ff)
         fpa_pkg::CMD_ADD:    result = a_ff + b_ff;
         fpa_pkg::CMD_SUB:    result = a_ff - b_ff;
         fpa_pkg::CMD_MUL:    result = prod_shift[31:0];
         fpa_pkg::CMD_DIV:    result = 32'd0;
         fpa_pkg::CMD_INC:    result = a_ff + 32'sd1;
         fpa_pkg::CMD_DEC:    result = a_ff - 32'sd1;
         fpa_pkg::CMD_TO_INT: result = a_shift;
         fpa_pkg::CMD_TO_FIX: result = a_ff << FRAC_BITS;
         default:             result = 32'd0;
      endcase
   end

   // The divider works on magnitudes; the quotient sign is fixed after the last cell.
   always_comb begin
      cell_out.valid    = valid_ff;
      cell_out.is_div   = (cmd_ff == fpa_pkg::CMD_DIV);
      cell_out.negate   = a_ff[31] ^ b_ff[31];
      cell_out.div_zero = (cmd_ff == fpa_pkg::CMD_DIV) && (b_ff == 32'sd0);
      cell_out.greater  = a_ff > b_ff;
      cell_out.less     = a_ff < b_ff;
      cell_out.equal    = a_ff == b_ff;
      cell_out.result   = result;
      cell_out.rem      = 32'd0;
      cell_out.divisor  = b_mag;
   end

   assign dvd_out = {a_mag, {FRAC_BITS{1'b0}}};

endmodule
`default_nettype wire

@@ src/fpa_cell.sv @@
// One restoring division step; other items pass through unchanged.
`default_nettype none
module fpa_cell #(
   parameter int DVD_W = 40
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fpa_pkg::cell_type cell_in,
   input  wire logic [DVD_W-1:0]  dvd_in,
   output fpa_pkg::cell_type      cell_out,
   output logic [DVD_W-1:0]       dvd_out
);

   fpa_pkg::cell_type cell_ff;
   fpa_pkg::cell_type cell_in_next;
   logic [DVD_W-1:0]  dvd_ff;
   logic [32:0]       trial;
   logic [32:0]       diff;
   logic              q_bit;

   assign trial = {cell_in.rem, dvd_in[DVD_W-1]};
   assign diff  = trial - {1'b0, cell_in.divisor};
   // The remainder stays below the divisor, so a borrow out of bit 32 means the trial fell short.
   assign q_bit = ~diff[32];

   always_comb begin
      cell_in_next = cell_in;
      if (cell_in.is_div) begin
         cell_in_next.rem    = q_bit ? diff[31:0] : trial[31:0];
         // Only the low 32 quotient bits survive the wrap.
         cell_in_next.result = {cell_in.result[30:0], q_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in_next;
      end
      dvd_ff <= {dvd_in[DVD_W-2:0], 1'b0};
   end

   assign cell_out = cell_ff;
   assign dvd_out  = dvd_ff;

endmodule
`default_nettype wire

@@ src/fixed_point_alu_q24_8_unit.sv @@
// Top level of the signed fixed-point ALU with a cell-chain divider.
//
//   channel   ports                               direction  handshake
//   request   start, busy, req_item               in         start && !busy
//   response  rsp_valid, rsp_item                 out        one-cycle strobe
//
// One item is taken every cycle while busy is low; results come out in order. Each
// item passes the operand/multiplier stage, the divider chain with one cell per
// dividend bit (32 + FRAC_BITS cells) and then the output register. Every command
// goes through the chain so results never reorder.
// busy is high only during reset; synchronous reset empties the chain.
`default_nettype none
module fixed_point_alu_q24_8_unit #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire fpa_pkg::req_type req_item,
   output logic                  rsp_valid,
   output fpa_pkg::rsp_type      rsp_item
);

   localparam int DVD_W = 32 + FRAC_BITS;

   fpa_pkg::cell_type cell_chain [0:DVD_W];
   logic [DVD_W-1:0]  dvd_chain  [0:DVD_W];

   assign busy = reset;

   fpa_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (start && !busy),
      .req_item  (req_item),
      .cell_out  (cell_chain[0]),
      .dvd_out   (dvd_chain[0])
   );

   for (genvar i = 0; i < DVD_W; i++) begin : g_cell
      fpa_cell #(
         .DVD_W (DVD_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (cell_chain[i]),
         .dvd_in   (dvd_chain[i]),
         .cell_out (cell_chain[i+1]),
         .dvd_out  (dvd_chain[i+1])
      );
   end

   fpa_pkg::cell_type last;
   fpa_pkg::rsp_type  rsp_in;
   fpa_pkg::rsp_type  rsp_ff;
   logic              rsp_valid_ff;

   assign last = cell_chain[DVD_W];

   always_comb begin
      rsp_in.a_greater      = last.greater;
      rsp_in.a_less         = last.less;
      rsp_in.a_equal        = last.equal;
      rsp_in.divide_by_zero = last.div_zero;
      if (last.is_div) begin
         if (last.div_zero) begin
            rsp_in.result_value = 32'sd0;
         end else if (last.negate) begin
            rsp_in.result_value = ~last.result + 32'd1;
         end else begin
            rsp_in.result_value = last.result;
         end
      end else begin
         rsp_in.result_value = last.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

@@ src/fpa_checker.sv @@
// Port-level checks on the fixed-point ALU and the bind that attaches them.
`default_nettype none
module fpa_checker #(
   parameter int FRAC_BITS = 8,
   localparam int LAT = FRAC_BITS + 34
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire fpa_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire fpa_pkg::rsp_type rsp_item
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("item accepted without a result at the fixed latency");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching accepted item");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_item.a_greater, rsp_item.a_less, rsp_item.a_equal}))
      else $error("compare flags are not exactly one of greater, less, equal");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.divide_by_zero) |-> (rsp_item.result_value == 32'sd0))
      else $error("divide by zero gave a nonzero result");

   a_dz_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.divide_by_zero ==
         $past((req_item.command == fpa_pkg::CMD_DIV) && (req_item.operand_b == 32'sd0), LAT)))
      else $error("divide-by-zero flag does not match the accepted item");

endmodule

bind fixed_point_alu_q24_8_unit fpa_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_fpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

@@ sim/fixed_point_alu_q24_8_unit_tb.sv @@
// Self-checking testbench for the Q24.8 fixed-point ALU, comparing each response to a model.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8_unit_tb;

   localparam int FRAC_BITS   = 8;
   localparam int LATENCY     = FRAC_BITS + 34;
   localparam int CYCLE_LIMIT = 300000;

   localparam logic signed [31:0] MAX_WORD = 32'sh7fff_ffff;
   localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_FIX  = 32'sh0000_0100;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   fpa_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   fpa_pkg::rsp_type rsp_item;

   fpa_pkg::rsp_type pending_results[$];
   int               fail_count  = 0;
   int               cycle_count = 0;

   fixed_point_alu_q24_8_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fixed_point_alu_q24_8_unit test failed");
         $finish;
      end
   end

   function automatic fpa_pkg::rsp_type alu_result(fpa_pkg::req_type item);
      fpa_pkg::rsp_type   res;
      longint             wide_a;
      longint             wide_b;
      longint             wide_r;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] r;
      a      = item.operand_a;
      b      = item.operand_b;
      wide_a = longint'(a);
      wide_b = longint'(b);
      r      = '0;
      res    = '0;
      case (fpa_pkg::cmd_type'(item.command))
         fpa_pkg::CMD_ADD: r = a + b;
         fpa_pkg::CMD_SUB: r = a - b;
         fpa_pkg::CMD_MUL: begin
            wide_r = (wide_a * wide_b) >>> FRAC_BITS;
            r      = wide_r[31:0];
         end
         fpa_pkg::CMD_DIV: begin
            if (b == 0) begin
               res.divide_by_zero = 1'b1;
            end else begin
               // SystemVerilog division truncates toward zero, as required.
               wide_r = (wide_a <<< FRAC_BITS) / wide_b;
               r      = wide_r[31:0];
            end
         end
         fpa_pkg::CMD_INC:    r = a + 32'sd1;
         fpa_pkg::CMD_DEC:    r = a - 32'sd1;
         fpa_pkg::CMD_TO_INT: r = a >>> FRAC_BITS;
         default:             r = a << FRAC_BITS;
      endcase
      res.result_value = r;
      res.a_greater    = (a > b);
      res.a_less       = (a < b);
      res.a_equal      = (a == b);
      return res;
   endfunction

   // Sends one item after an optional random gap; returns in the step it is accepted.
   task automatic send_alu_item(fpa_pkg::cmd_type cmd, logic signed [31:0] a,
                                logic signed [31:0] b, int idle_pct);
      fpa_pkg::req_type item;
      item.command   = cmd;
      item.operand_a = a;
      item.operand_b = b;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      pending_results.push_back(alu_result(item));
   endtask

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      fpa_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: result_value %0d", rsp_item.result_value);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_value", want.result_value, rsp_item.result_value);
            check_field("a_greater", want.a_greater, rsp_item.a_greater);
            check_field("a_less", want.a_less, rsp_item.a_less);
            check_field("a_equal", want.a_equal, rsp_item.a_equal);
            check_field("divide_by_zero", want.divide_by_zero, rsp_item.divide_by_zero);
         end
      end
   end

   task automatic test_add_sub();
      send_alu_item(fpa_pkg::CMD_ADD, MAX_WORD, 32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_ADD, MIN_WORD, -32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_ADD, 32'sd5, 32'sd5, 0);
      send_alu_item(fpa_pkg::CMD_SUB, MIN_WORD, 32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_SUB, MAX_WORD, -32'sd1, 0);
   endtask

   task automatic test_mul_div();
      send_alu_item(fpa_pkg::CMD_MUL, MAX_WORD, MAX_WORD, 0);
      send_alu_item(fpa_pkg::CMD_MUL, MIN_WORD, MIN_WORD, 0);
      send_alu_item(fpa_pkg::CMD_MUL, MIN_WORD, -32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_MUL, ONE_FIX, ONE_FIX, 0);
      send_alu_item(fpa_pkg::CMD_MUL, -32'sh180, 32'sh200, 0);
      send_alu_item(fpa_pkg::CMD_DIV, MIN_WORD, -32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_DIV, -32'sd1, 32'sd3, 0);
      send_alu_item(fpa_pkg::CMD_DIV, MAX_WORD, 32'sd1, 0);
   endtask

   task automatic test_divide_by_zero();
      send_alu_item(fpa_pkg::CMD_DIV, ONE_FIX, 32'sd0, 0);
      send_alu_item(fpa_pkg::CMD_DIV, MIN_WORD, 32'sd0, 0);
      send_alu_item(fpa_pkg::CMD_DIV, 32'sd0, 32'sd0, 0);
   endtask

   // Unary commands still report the compare flags against operand_b.
   task automatic test_unary();
      send_alu_item(fpa_pkg::CMD_INC, MAX_WORD, MIN_WORD, 0);
      send_alu_item(fpa_pkg::CMD_DEC, MIN_WORD, MAX_WORD, 0);
      send_alu_item(fpa_pkg::CMD_TO_INT, -32'sd1, -32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_TO_INT, MIN_WORD, 32'sd0, 0);
      send_alu_item(fpa_pkg::CMD_TO_INT, -32'sh101, 32'sh1ff, 0);
      send_alu_item(fpa_pkg::CMD_TO_FIX, MAX_WORD, 32'sd0, 0);
      send_alu_item(fpa_pkg::CMD_TO_FIX, 32'sh0080_0000, -32'sd1, 0);
      send_alu_item(fpa_pkg::CMD_TO_FIX, MIN_WORD, MIN_WORD, 0);
   endtask

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(3))
         0: return $signed(32'($urandom_range(1023))) - 32'sd512;
         1: begin
            case ($urandom_range(4))
               0: return MAX_WORD;
               1: return MIN_WORD;
               2: return 32'sd0;
               3: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic test_random_traffic(int count, int idle_pct);
      fpa_pkg::cmd_type   cmd;
      logic signed [31:0] a;
      logic signed [31:0] b;
      for (int i = 0; i < count; i++) begin
         cmd = fpa_pkg::cmd_type'($urandom_range(7));
         a   = random_operand();
         b   = random_operand();
         case ($urandom_range(9))
            0: b = a;
            1: b = 32'sd0;
            default: ;
         endcase
         send_alu_item(cmd, a, b, idle_pct);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_add_sub();
      test_mul_div();
      test_divide_by_zero();
      test_unary();
      test_random_traffic(370, 6);
      test_random_traffic(370, 55);
      test_random_traffic(370, 0);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("fixed_point_alu_q24_8_unit test passed");
      end else begin
         $display("fixed_point_alu_q24_8_unit test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
